// ----- design/hvd_pkg.sv -----
// Shared widths, constants, types and helper functions of the haversine distance block.
package hvd_pkg;

  // Field widths of the requests, the result and the radius register.
  localparam int LAT_W    = 28;
  localparam int LNG_W    = 29;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 26;

  // Internal widths.
  localparam int Q        = 30;          // Q30 fixed point
  localparam int ANG_W    = 31;          // signed angle in degrees * 2^21
  localparam int TURN_W   = 30;          // reduced angle, unsigned
  localparam int CW       = 34;          // CORDIC datapath width
  localparam int ROOT_W   = Q + 1;       // square root, up to 1.0 in Q30
  localparam int REM_W    = 62;          // square root remainder and trial
  localparam int ZPOS_W   = 31;          // non-negative final angle
  localparam int PROD_W   = RADIUS_W + ZPOS_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 26'd52707179;

  // Angle reduction constants, degrees * 2^21.
  localparam logic [TURN_W-1:0] TURN         = 30'd754974720;
  localparam logic [TURN_W-1:0] HALF_TURN    = 30'd377487360;
  localparam logic [TURN_W-1:0] QUARTER_TURN = 30'd188743680;

  // pi in Q60, and pi/180 in Q36 rounded to nearest.
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG2RAD_Q36 = ((PI_Q60 / 64'd180) + (64'd1 << 23)) >> 24;
  localparam logic [30:0] DEG2RAD     = DEG2RAD_Q36[30:0];

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [31:0]   q_t;

  localparam cw_t ONE_CW = 34'sd1073741824;

  // Restoring division, used only while elaborating the constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Floor square root, used only while elaborating the constant tables.
  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] w;
    res = '0;
    bt  = 64'd1 << 62;
    w   = v;
    while (bt > w) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (w >= res + bt) begin
        w   = w - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Arctangent of 2^-i in Q30, from the alternating series in Q62.
  function automatic cw_t atan_q30(input int i);
    logic [63:0] r;
    logic [63:0] term;
    int k;
    int sh;
    r = '0;
    if (i == 0) begin
      r = PI_Q60;
    end else begin
      k  = 0;
      sh = 62 - i;
      while (sh >= 0) begin
        term = udiv64(64'd1 << sh, 64'(2 * k + 1));
        r    = (k % 2 == 1) ? r - term : r + term;
        k    = k + 1;
        sh   = 62 - i * (2 * k + 1);
      end
    end
    return cw_t'((r + (64'd1 << 31)) >> 32);
  endfunction

  // Inverse CORDIC gain in Q30 for a given number of micro-rotations.
  function automatic cw_t inv_gain(input int n);
    logic [63:0] g;
    logic [63:0] qv;
    logic [63:0] s;
    g = 64'd1 << Q;
    for (int i = 0; i < n; i++) begin
      qv = (64'd1 << 60) + ((2 * i <= 60) ? (64'd1 << (60 - 2 * i)) : 64'd0);
      s  = isqrt_c(qv);
      g  = udiv64((g << Q) + (s >> 1), s);
    end
    return cw_t'(g);
  endfunction

  // Clamp a CORDIC output to [0, 1.0].
  function automatic logic [ROOT_W-1:0] clamp01(input cw_t v);
    logic [ROOT_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > ONE_CW) r = ROOT_W'(ONE_CW);
    else r = v[ROOT_W-1:0];
    return r;
  endfunction

  // Q30 product, rounded half up.
  function automatic q_t mul_q(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (Q - 1));
    return q_t'(p >>> Q);
  endfunction

endpackage

// ----- design/hvd_in_if.sv -----
// Request channel carrying the two points.
interface hvd_in_if import hvd_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_first;
  logic signed [LNG_W-1:0] lng_first;
  logic signed [LAT_W-1:0] lat_second;
  logic signed [LNG_W-1:0] lng_second;

  modport source (output valid, lat_first, lng_first, lat_second, lng_second, input ready);
  modport sink   (input valid, lat_first, lng_first, lat_second, lng_second, output ready);
endinterface

// ----- design/hvd_out_if.sv -----
// Result channel carrying the distance.
interface hvd_out_if import hvd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] great_circle_distance;

  modport source (output valid, great_circle_distance, input ready);
  modport sink   (input valid, great_circle_distance, output ready);
endinterface

// ----- design/haversine_distance.sv -----
// Top level: pipelined haversine great-circle distance.
//
//   channel   dir  handshake     contents
//   in_i      in   valid/ready   lat_first, lng_first, lat_second, lng_second
//   out_o     out  valid/ready   great_circle_distance
//   cfg       in   cfg_we_i      earth_radius (cfg_wdata_i)
//
// One request enters per cycle unless the pipeline holds; it passes the input and
// angle registers, the rotation CORDIC cells, the product registers, the 31 square root
// digit cells, the vectoring CORDIC cells and the scaling registers to reach the output
// buffer. Reset clears the valid bits and buffer count and loads the default radius.
// The whole pipeline advances together; a two-entry output buffer keeps requests
// flowing while one result waits, and the pipeline holds only when it is full.
module haversine_distance import hvd_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RADIUS_W-1:0] cfg_wdata_i,
  hvd_in_if.sink              in_i,
  hvd_out_if.source           out_o
);

  localparam int  N    = CORDIC_STAGES;
  localparam int  LAT  = 2 * N + 41;
  localparam cw_t GAIN = inv_gain(N);

  logic                en;
  logic                accept;
  logic [LAT-1:0]      valid_q;
  logic [RADIUS_W-1:0] radius_q;

  // Radius register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Output buffer control.
  logic [DIST_W-1:0] buf_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push, pop;
  logic [DIST_W-1:0] dist_q;

  assign en          = (cnt_q != 2'd2) || out_o.ready;
  assign accept      = in_i.valid && en;
  assign in_i.ready  = en;
  assign push        = en && valid_q[LAT-1];
  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.great_circle_distance = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (en) valid_q <= {valid_q[LAT-2:0], accept};
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= dist_q;
  end

  // Angle differences and doubled latitudes; lanes are dlat, dlng, lat1, lat2.
  logic signed [ANG_W-1:0] ang_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= ANG_W'(in_i.lat_first) - ANG_W'(in_i.lat_second);
      ang_q[1] <= ANG_W'(in_i.lng_first) - ANG_W'(in_i.lng_second);
      ang_q[2] <= ANG_W'(in_i.lat_first) + ANG_W'(in_i.lat_first);
      ang_q[3] <= ANG_W'(in_i.lat_second) + ANG_W'(in_i.lat_second);
    end
  end

  // Four rotation CORDIC chains.
  cw_t  rx [4][N+1];
  cw_t  ry [4][N+1];
  cw_t  rz [4][N+1];
  logic rt [4][N+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign rx[l][0] = GAIN;
    assign ry[l][0] = '0;

    hvd_angle_prep u_prep (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (ang_q[l]),
      .z_o     (rz[l][0]),
      .neg_o   (rt[l][0])
    );

    for (genvar i = 0; i < N; i++) begin : g_rot
      hvd_cordic_cell #(
        .SHIFT  (i),
        .ATAN   (atan_q30(i)),
        .VECTOR (1'b0)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][i]),
        .y_i   (ry[l][i]),
        .z_i   (rz[l][i]),
        .tag_i (rt[l][i]),
        .x_o   (rx[l][i+1]),
        .y_o   (ry[l][i+1]),
        .z_o   (rz[l][i+1]),
        .tag_o (rt[l][i+1])
      );
    end
  end

  // Clamp and square the sines, multiply the cosines.
  q_t sa, sb, c1, c2;
  q_t sasa_q, sbsb_q, c12_q, sasa2_q, t_q;
  logic signed [32:0] hsum;
  logic [ROOT_W-1:0]  h_d, h_q;

  always_comb begin
    sa = q_t'(clamp01(ry[0][N]));
    sb = q_t'(clamp01(ry[1][N]));
    c1 = rt[2][N] ? -q_t'(clamp01(rx[2][N])) : q_t'(clamp01(rx[2][N]));
    c2 = rt[3][N] ? -q_t'(clamp01(rx[3][N])) : q_t'(clamp01(rx[3][N]));
    hsum = 33'(sasa2_q) + 33'(t_q);
    if (hsum < 0) h_d = '0;
    else if (hsum > 33'(ONE_CW)) h_d = ROOT_W'(ONE_CW);
    else h_d = hsum[ROOT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sasa_q  <= mul_q(sa, sa);
      sbsb_q  <= mul_q(sb, sb);
      c12_q   <= mul_q(c1, c2);
      t_q     <= mul_q(c12_q, sbsb_q);
      sasa2_q <= sasa_q;
      h_q     <= h_d;
    end
  end

  // Square roots of h and 1 - h, one digit per cell.
  logic [REM_W-1:0]  rem_a [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem_b [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_a [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_b [SQRT_STEPS+1];

  assign rem_a[0]  = REM_W'(h_q) << Q;
  assign rem_b[0]  = REM_W'(ROOT_W'(ONE_CW) - h_q) << Q;
  assign root_a[0] = '0;
  assign root_b[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    hvd_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_sqrt_a (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_a[j]),
      .root_i (root_a[j]),
      .rem_o  (rem_a[j+1]),
      .root_o (root_a[j+1])
    );
    hvd_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_sqrt_b (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_b[j]),
      .root_i (root_b[j]),
      .rem_o  (rem_b[j+1]),
      .root_o (root_b[j+1])
    );
  end

  // Vectoring CORDIC: atan2(sqrt(h), sqrt(1 - h)).
  cw_t  vx [N+1];
  cw_t  vy [N+1];
  cw_t  vz [N+1];
  logic vt [N+1];

  assign vx[0] = $signed({{(CW - ROOT_W){1'b0}}, root_b[SQRT_STEPS]});
  assign vy[0] = $signed({{(CW - ROOT_W){1'b0}}, root_a[SQRT_STEPS]});
  assign vz[0] = '0;
  assign vt[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    hvd_cordic_cell #(
      .SHIFT  (i),
      .ATAN   (atan_q30(i)),
      .VECTOR (1'b1)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .tag_i (vt[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1]),
      .tag_o (vt[i+1])
    );
  end

  // Scale by the radius, then round and saturate.
  logic [ZPOS_W-1:0] zpos;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W:0]   rsum;
  logic [26:0]       dist_d;

  always_comb begin
    zpos   = (vz[N] < 0) ? '0 : vz[N][ZPOS_W-1:0];
    rsum   = (PROD_W + 1)'(prod_q) + ((PROD_W + 1)'(1) << 28);
    dist_d = rsum[PROD_W:29];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PROD_W'(radius_q) * PROD_W'(zpos);
      dist_q <= (dist_d > 27'(DIST_MAX)) ? DIST_MAX : dist_d[DIST_W-1:0];
    end
  end

endmodule

// ----- design/hvd_angle_prep.sv -----
// Reduces an angle to the first quadrant and scales it to radians in Q30.
module hvd_angle_prep import hvd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output cw_t                     z_o,
  output logic                    neg_o
);

  logic [TURN_W-1:0] wrap_q, fold1_q, fold2_q;
  logic              neg2_q, neg_q;
  cw_t               z_q;
  logic [TURN_W-1:0] wrap_d, fold1_d, fold2_d;
  logic              neg2_d;
  logic [59:0]       prod;

  // Wrap into one turn, fold into a half turn, then into a quarter turn.
  always_comb begin
    if (angle_i < 0) wrap_d = TURN_W'(angle_i + ANG_W'(TURN));
    else wrap_d = TURN_W'(angle_i);
    fold1_d = (wrap_q > HALF_TURN) ? TURN - wrap_q : wrap_q;
    if (fold1_q > QUARTER_TURN) begin
      fold2_d = HALF_TURN - fold1_q;
      neg2_d  = 1'b1;
    end else begin
      fold2_d = fold1_q;
      neg2_d  = 1'b0;
    end
    prod = 60'(fold2_q) * 60'(DEG2RAD) + (60'd1 << 26);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_q  <= wrap_d;
      fold1_q <= fold1_d;
      fold2_q <= fold2_d;
      neg2_q  <= neg2_d;
      z_q     <= cw_t'(prod >> 27);
      neg_q   <= neg2_q;
    end
  end

  assign z_o   = z_q;
  assign neg_o = neg_q;

endmodule

// ----- design/hvd_cordic_cell.sv -----
// One CORDIC micro-rotation with its output register.
module hvd_cordic_cell import hvd_pkg::*; #(
  parameter int  SHIFT  = 0,
  parameter cw_t ATAN   = '0,
  parameter bit  VECTOR = 1'b0
) (
  input  logic clk_i,
  input  logic en_i,
  input  cw_t  x_i,
  input  cw_t  y_i,
  input  cw_t  z_i,
  input  logic tag_i,
  output cw_t  x_o,
  output cw_t  y_o,
  output cw_t  z_o,
  output logic tag_o
);

  cw_t  x_q, y_q, z_q;
  logic tag_q;
  cw_t  dx, dy;
  logic cw_dir;

  // Vectoring drives y toward zero, rotation drives z toward zero.
  always_comb begin
    dx     = y_i >>> SHIFT;
    dy     = x_i >>> SHIFT;
    cw_dir = VECTOR ? (y_i > 0) : (z_i < 0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cw_dir) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + ATAN;
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - ATAN;
      end
      tag_q <= tag_i;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign tag_o = tag_q;

endmodule

// ----- design/hvd_sqrt_cell.sv -----
// One digit of a restoring square root with its output register.
module hvd_sqrt_cell import hvd_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  trial;

  // (root + 2^BIT)^2 - root^2; root has no bits at or below BIT yet.
  assign trial = (REM_W'(root_i) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_i >= trial) begin
        rem_q  <= rem_i - trial;
        root_q <= root_i | (ROOT_W'(1) << BIT);
      end else begin
        rem_q  <= rem_i;
        root_q <= root_i;
      end
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule
